// ===== rtl/scp_pkg.sv =====
// Shared constants and types for the segment closest point unit.
`timescale 1ns / 1ps
package scp_pkg;
    localparam int COORD_WIDTH   = 16;
    localparam int FRACTION_BITS = 16;
    localparam int QUEUE_DEPTH   = 2;

    // Outcome class decided by the front part.
    typedef enum logic [1:0] {
        CLS_START,
        CLS_END,
        CLS_INSIDE
    } t_cls;
endpackage

// ===== rtl/scp_if.sv =====
// Valid/ready channel interface carrying one request payload.
`timescale 1ns / 1ps
interface scp_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/scp_front.sv =====
// Front part: differences, dot products and classification of each request.
`timescale 1ns / 1ps
module scp_front #(
    parameter int CW = scp_pkg::COORD_WIDTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic signed [CW-1:0] i_sx,
    input  logic signed [CW-1:0] i_sy,
    input  logic signed [CW-1:0] i_ex,
    input  logic signed [CW-1:0] i_ey,
    input  logic signed [CW-1:0] i_qx,
    input  logic signed [CW-1:0] i_qy,
    output logic                o_valid,
    input  logic                i_ready,
    output scp_pkg::t_cls       o_cls,
    output logic [2*CW+1:0]     o_c1,
    output logic [2*CW+1:0]     o_c2,
    output logic signed [CW-1:0] o_sx,
    output logic signed [CW-1:0] o_sy,
    output logic signed [CW-1:0] o_ex,
    output logic signed [CW-1:0] o_ey,
    output logic signed [CW:0]   o_vx,
    output logic signed [CW:0]   o_vy
);
    localparam int PW = 2*CW + 3;

    // Stage one: products of the axis differences.
    logic                r_v1;
    logic signed [PW-1:0] r_p1, r_p2, r_p3, r_p4;
    logic signed [CW-1:0] r1_sx, r1_sy, r1_ex, r1_ey;
    logic signed [CW:0]   r1_vx, r1_vy;
    // Stage two: sums and class.
    logic                r_v2;
    scp_pkg::t_cls       r_cls;
    logic [2*CW+1:0]     r_c1, r_c2;
    logic signed [CW-1:0] r2_sx, r2_sy, r2_ex, r2_ey;
    logic signed [CW:0]   r2_vx, r2_vy;

    logic signed [CW:0]  vx, vy, wx, wy;
    logic signed [PW-1:0] c1, c2;
    logic                adv2, adv1;

    assign vx = {i_ex[CW-1], i_ex} - {i_sx[CW-1], i_sx};
    assign vy = {i_ey[CW-1], i_ey} - {i_sy[CW-1], i_sy};
    assign wx = {i_qx[CW-1], i_qx} - {i_sx[CW-1], i_sx};
    assign wy = {i_qy[CW-1], i_qy} - {i_sy[CW-1], i_sy};
    assign c1 = r_p1 + r_p2;
    assign c2 = r_p3 + r_p4;

    assign adv2    = !r_v2 || i_ready;
    assign adv1    = !r_v1 || adv2;
    assign o_ready = adv1;

    // Pipeline valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= i_valid;
            if (adv2) r_v2 <= r_v1;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_p1  <= PW'(wx * vx);
            r_p2  <= PW'(wy * vy);
            r_p3  <= PW'(vx * vx);
            r_p4  <= PW'(vy * vy);
            r1_sx <= i_sx; r1_sy <= i_sy; r1_ex <= i_ex; r1_ey <= i_ey;
            r1_vx <= vx;   r1_vy <= vy;
        end
        if (adv2) begin
            if (c1 <= 0)       r_cls <= scp_pkg::CLS_START;
            else if (c2 <= c1) r_cls <= scp_pkg::CLS_END;
            else               r_cls <= scp_pkg::CLS_INSIDE;
            r_c1  <= c1[2*CW+1:0];
            r_c2  <= c2[2*CW+1:0];
            r2_sx <= r1_sx; r2_sy <= r1_sy; r2_ex <= r1_ex; r2_ey <= r1_ey;
            r2_vx <= r1_vx; r2_vy <= r1_vy;
        end
    end

    assign o_valid = r_v2;
    assign o_cls = r_cls;
    assign o_c1 = r_c1;
    assign o_c2 = r_c2;
    assign o_sx = r2_sx; assign o_sy = r2_sy;
    assign o_ex = r2_ex; assign o_ey = r2_ey;
    assign o_vx = r2_vx; assign o_vy = r2_vy;
endmodule

// ===== rtl/scp_queue.sv =====
// Short first-in first-out queue that decouples the front and back parts.
`timescale 1ns / 1ps
module scp_queue #(
    parameter int W     = 8,
    parameter int DEPTH = scp_pkg::QUEUE_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic [W-1:0] i_data,
    output logic         o_valid,
    input  logic         i_ready,
    output logic [W-1:0] o_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic          push, pop;

    assign o_ready = (r_cnt != (AW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign push = i_valid && o_ready;
    assign pop  = o_valid && i_ready;
    assign o_data = r_mem[r_rp];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (push) r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            if (pop)  r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_data;
    end
endmodule

// ===== rtl/scp_back.sv =====
// Back part: pipelined restoring divider and interpolation of the point.
`timescale 1ns / 1ps
module scp_back #(
    parameter int CW = scp_pkg::COORD_WIDTH,
    parameter int FB = scp_pkg::FRACTION_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  scp_pkg::t_cls        i_cls,
    input  logic [2*CW+1:0]      i_c1,
    input  logic [2*CW+1:0]      i_c2,
    input  logic signed [CW-1:0] i_sx,
    input  logic signed [CW-1:0] i_sy,
    input  logic signed [CW-1:0] i_ex,
    input  logic signed [CW-1:0] i_ey,
    input  logic signed [CW:0]   i_vx,
    input  logic signed [CW:0]   i_vy,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic signed [CW-1:0] o_nx,
    output logic signed [CW-1:0] o_ny,
    output logic [FB:0]          o_t
);
    localparam int DW = 2*CW + 3;   // remainder width, one bit of headroom
    localparam int NS = FB + 3;     // entry, FB divide stages, multiply, output

    logic              r_v   [NS];
    scp_pkg::t_cls     r_cls [FB+1];
    logic [DW-1:0]     r_rem [FB+1];
    logic [DW-1:0]     r_den [FB+1];
    logic [FB-1:0]     r_q   [FB+1];
    logic signed [CW-1:0] r_sx [FB+1], r_sy [FB+1], r_ex [FB+1], r_ey [FB+1];
    logic signed [CW:0]   r_vx [FB+1], r_vy [FB+1];
    // Multiply stage.
    scp_pkg::t_cls     r_mcls;
    logic [FB-1:0]     r_mq;
    logic signed [CW+FB+1:0] r_mx, r_my;
    logic signed [CW-1:0] r_msx, r_msy, r_mex, r_mey;
    // Output register.
    logic signed [CW-1:0] r_nx, r_ny;
    logic [FB:0]          r_t;

    logic adv;
    logic signed [CW+FB+1:0] offx, offy;

    // One shared stall: the whole back pipeline moves when the output is free.
    assign adv     = !r_v[NS-1] || i_ready;
    assign o_ready = adv;

    // Valid chain.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NS; k++) r_v[k] <= 1'b0;
        end else if (adv) begin
            r_v[0] <= i_valid;
            for (int k = 1; k < NS; k++) r_v[k] <= r_v[k-1];
        end
    end

    // Entry stage and one quotient bit per stage.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_cls[0] <= i_cls;
            r_rem[0] <= DW'(i_c1);
            r_den[0] <= DW'(i_c2);
            r_q[0]   <= '0;
            r_sx[0] <= i_sx; r_sy[0] <= i_sy; r_ex[0] <= i_ex; r_ey[0] <= i_ey;
            r_vx[0] <= i_vx; r_vy[0] <= i_vy;
            for (int k = 1; k <= FB; k++) begin
                if ({r_rem[k-1][DW-2:0], 1'b0} >= r_den[k-1]) begin
                    r_rem[k] <= {r_rem[k-1][DW-2:0], 1'b0} - r_den[k-1];
                    r_q[k]   <= {r_q[k-1][FB-2:0], 1'b1};
                end else begin
                    r_rem[k] <= {r_rem[k-1][DW-2:0], 1'b0};
                    r_q[k]   <= {r_q[k-1][FB-2:0], 1'b0};
                end
                r_cls[k] <= r_cls[k-1]; r_den[k] <= r_den[k-1];
                r_sx[k] <= r_sx[k-1]; r_sy[k] <= r_sy[k-1];
                r_ex[k] <= r_ex[k-1]; r_ey[k] <= r_ey[k-1];
                r_vx[k] <= r_vx[k-1]; r_vy[k] <= r_vy[k-1];
            end
        end
    end

    // Offsets along the segment, then the shifted sum.
    assign offx = r_mx >>> FB;
    assign offy = r_my >>> FB;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_mcls <= r_cls[FB];
            r_mq   <= r_q[FB];
            r_mx   <= r_vx[FB] * $signed({1'b0, r_q[FB]});
            r_my   <= r_vy[FB] * $signed({1'b0, r_q[FB]});
            r_msx <= r_sx[FB]; r_msy <= r_sy[FB];
            r_mex <= r_ex[FB]; r_mey <= r_ey[FB];
            case (r_mcls)
                scp_pkg::CLS_START: begin
                    r_nx <= r_msx; r_ny <= r_msy; r_t <= '0;
                end
                scp_pkg::CLS_END: begin
                    r_nx <= r_mex; r_ny <= r_mey; r_t <= {1'b1, {FB{1'b0}}};
                end
                default: begin
                    r_nx <= r_msx + offx[CW-1:0];
                    r_ny <= r_msy + offy[CW-1:0];
                    r_t  <= {1'b0, r_mq};
                end
            endcase
        end
    end

    assign o_valid = r_v[NS-1];
    assign o_nx = r_nx;
    assign o_ny = r_ny;
    assign o_t  = r_t;
endmodule

// ===== rtl/segment_closest_point_unit.sv =====
// Top level of the segment closest point unit.
`timescale 1ns / 1ps
// Streams one request per cycle when nothing stalls: start, end and query
// points in, the closest point on the segment and the clamped parameter out.
// A request passes through the products and then the dot-product sums and
// class in the front part, the queue, an entry register in the back part,
// then one restoring-divider stage per quotient bit, a multiply stage and
// the output register. Both channels use valid/ready; the queue lets the
// front keep accepting while the back is stalled, until the queue is full.
module segment_closest_point_unit #(
    parameter int COORD_WIDTH   = scp_pkg::COORD_WIDTH,
    parameter int FRACTION_BITS = scp_pkg::FRACTION_BITS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    scp_if.sink   i_req,
    scp_if.source o_res
);
    localparam int CW = COORD_WIDTH;
    localparam int FB = FRACTION_BITS;
    localparam int QW = 2 + 2*(2*CW+2) + 4*CW + 2*(CW+1);

    logic                 f_valid, f_ready, b_valid, b_ready;
    scp_pkg::t_cls        f_cls, b_cls;
    logic [2*CW+1:0]      f_c1, f_c2, b_c1, b_c2;
    logic signed [CW-1:0] f_sx, f_sy, f_ex, f_ey, b_sx, b_sy, b_ex, b_ey;
    logic signed [CW:0]   f_vx, f_vy, b_vx, b_vy;
    logic [QW-1:0]        q_in, q_out;

    scp_front #(.CW(CW)) u_front (
        .i_clk, .i_rst_n,
        .i_valid(i_req.valid), .o_ready(i_req.ready),
        .i_sx(i_req.data.start_x), .i_sy(i_req.data.start_y),
        .i_ex(i_req.data.end_x),   .i_ey(i_req.data.end_y),
        .i_qx(i_req.data.query_x), .i_qy(i_req.data.query_y),
        .o_valid(f_valid), .i_ready(f_ready),
        .o_cls(f_cls), .o_c1(f_c1), .o_c2(f_c2),
        .o_sx(f_sx), .o_sy(f_sy), .o_ex(f_ex), .o_ey(f_ey),
        .o_vx(f_vx), .o_vy(f_vy)
    );

    assign q_in = {f_cls, f_c1, f_c2, f_sx, f_sy, f_ex, f_ey, f_vx, f_vy};
    assign {b_cls, b_c1, b_c2, b_sx, b_sy, b_ex, b_ey, b_vx, b_vy} = q_out;

    scp_queue #(.W(QW)) u_queue (
        .i_clk, .i_rst_n,
        .i_valid(f_valid), .o_ready(f_ready), .i_data(q_in),
        .o_valid(b_valid), .i_ready(b_ready), .o_data(q_out)
    );

    scp_back #(.CW(CW), .FB(FB)) u_back (
        .i_clk, .i_rst_n,
        .i_valid(b_valid), .o_ready(b_ready),
        .i_cls(b_cls), .i_c1(b_c1), .i_c2(b_c2),
        .i_sx(b_sx), .i_sy(b_sy), .i_ex(b_ex), .i_ey(b_ey),
        .i_vx(b_vx), .i_vy(b_vy),
        .o_valid(o_res.valid), .i_ready(o_res.ready),
        .o_nx(o_res.data.near_x), .o_ny(o_res.data.near_y),
        .o_t(o_res.data.fraction)
    );

    // The fraction never exceeds one whole unit.
    a_frac_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.data.fraction <= (FB+1)'(1 << FB)))
        else $error("fraction above one");

    // A stalled result holds its value.
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.ready) |=> $stable(o_res.data))
        else $error("result changed while stalled");

    // The front keeps offering a request that the queue has refused.
    a_queue_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (f_valid && !f_ready) |=> f_valid)
        else $error("front lost an item");
endmodule
